// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge, with reset held off.
`define PSPF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pspf assertion failed");
// Check a property on every rising clock edge, reset included.
`define PSPF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pspf assertion failed");
`else
`define PSPF_ASSERT(label, prop)
`define PSPF_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== sv/pspf_pkg.sv =====
// Package with frame constants, status codes and result types.
`timescale 1ns / 1ps
package pspf_pkg;

    localparam logic [7:0]  START_FIRST       = 8'h42;
    localparam logic [7:0]  START_SECOND      = 8'h4D;
    localparam logic [15:0] START_SUM         = 16'h008F;
    localparam logic [15:0] FRAME_LENGTH_WORD = 16'h001C;

    // Frame byte positions
    localparam logic [4:0] IDX_FIRST_BODY  = 5'd2;
    localparam logic [4:0] IDX_LENGTH_LO   = 5'd3;
    localparam logic [4:0] IDX_VALUE_FIRST = 5'd11;
    localparam logic [4:0] IDX_VALUE_LAST  = 5'd27;
    localparam logic [4:0] IDX_SUM_END     = 5'd30;
    localparam logic [4:0] IDX_LAST        = 5'd31;

    localparam int VALUE_COUNT = 9;

    typedef logic [15:0] word_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_START    = 2'd1,
        STATUS_BAD_LENGTH   = 2'd2,
        STATUS_BAD_CHECKSUM = 2'd3
    } status_t;

    typedef struct packed {
        status_t                     status;
        word_t [VALUE_COUNT-1:0]     values;
    } result_t;

endpackage

// ===== sv/pspf_in_if.sv =====
// Byte input channel: valid, ready and one received byte.
`timescale 1ns / 1ps
interface pspf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/pspf_out_if.sv =====
// Result channel: valid, ready, status and the nine value words.
`timescale 1ns / 1ps
interface pspf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
    logic [15:0] count_0_3;
    logic [15:0] count_0_5;
    logic [15:0] count_1_0;
    logic [15:0] count_2_5;
    logic [15:0] count_5_0;
    logic [15:0] count_10;

    modport source (output valid, output status, output pm1_0, output pm2_5, output pm10,
                    output count_0_3, output count_0_5, output count_1_0,
                    output count_2_5, output count_5_0, output count_10, input ready);
    modport sink   (input valid, input status, input pm1_0, input pm2_5, input pm10,
                    input count_0_3, input count_0_5, input count_1_0,
                    input count_2_5, input count_5_0, input count_10, output ready);
endinterface

// ===== sv/particle_sensor_frame_parser_unit.sv =====
// Particle sensor frame parser: top level joining the parser and result queue.
//
// Takes one serial byte per beat and parses 32-byte frames that open with 0x42 0x4D.
// A byte is taken every cycle while the result queue has room; the parser updates
// its state in the cycle the byte is accepted, and the result of a frame (or of a
// bad second start byte) is pushed into the result queue and offered on the result
// channel once it heads the queue. Results pass through a two-entry queue, so input
// ready drops only when two results wait unclaimed. Status: 0 ok, 1 bad second start
// byte, 2 bad length, 3 bad checksum; the nine value words read zero on every error.
`timescale 1ns / 1ps
module particle_sensor_frame_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    pspf_in_if.sink    rx,
    pspf_out_if.source frame
);
    import pspf_pkg::*;

    logic    beat;
    logic    emit;
    logic    queue_ready;
    result_t parse_result;
    result_t out_data;

    assign rx.ready = queue_ready;
    assign beat     = rx.valid && queue_ready;

    pspf_frame_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .in_byte (rx.rx_byte),
        .emit    (emit),
        .result  (parse_result)
    );

    pspf_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (parse_result),
        .push_ready (queue_ready),
        .pop_valid  (frame.valid),
        .pop_ready  (frame.ready),
        .pop_data   (out_data)
    );

    // Spread the result beat over the channel fields
    assign frame.status    = out_data.status;
    assign frame.pm1_0     = out_data.values[0];
    assign frame.pm2_5     = out_data.values[1];
    assign frame.pm10      = out_data.values[2];
    assign frame.count_0_3 = out_data.values[3];
    assign frame.count_0_5 = out_data.values[4];
    assign frame.count_1_0 = out_data.values[5];
    assign frame.count_2_5 = out_data.values[6];
    assign frame.count_5_0 = out_data.values[7];
    assign frame.count_10  = out_data.values[8];

endmodule

// ===== sv/pspf_frame_parser.sv =====
// Frame state machine: start hunt, word assembly, checksum and result build.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pspf_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [7:0]        in_byte,
    output logic              emit,
    output pspf_pkg::result_t result
);
    import pspf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_SECOND  = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [4:0]              idx_reg, idx_next;
    logic [15:0]             sum_reg, sum_next;
    logic [15:0]             len_reg, len_next;
    logic [7:0]              pend_reg, pend_next;
    word_t [VALUE_COUNT-1:0] value_reg;
    logic                    wr_en;
    logic [3:0]              wr_idx;
    logic [4:0]              value_off;
    word_t                   word;
    status_t                 status;
    logic                    with_values;

    assign word      = {pend_reg, in_byte};
    assign value_off = idx_reg - IDX_VALUE_FIRST;
    assign wr_idx    = value_off[4:1];

    // Advance the frame state on each accepted beat
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        wr_en       = 1'b0;
        emit        = 1'b0;
        status      = STATUS_OK;
        with_values = 1'b0;
        if (beat)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    if (in_byte != START_SECOND)
                    begin
                        // Drop back to hunting without looking at this byte again
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        status     = STATUS_BAD_START;
                    end
                    else
                    begin
                        sum_next   = START_SUM;
                        idx_next   = IDX_FIRST_BODY;
                        phase_next = PH_COLLECT;
                    end
                end
                PH_COLLECT:
                begin
                    if (idx_reg < IDX_SUM_END)
                        sum_next = sum_reg + {8'd0, in_byte};
                    // Wraps to zero after the last frame byte
                    idx_next = idx_reg + 5'd1;
                    if (!idx_reg[0])
                        pend_next = in_byte;
                    else if (idx_reg == IDX_LENGTH_LO)
                        len_next = word;
                    else if (idx_reg >= IDX_VALUE_FIRST && idx_reg <= IDX_VALUE_LAST)
                        wr_en = 1'b1;
                    else if (idx_reg == IDX_LAST)
                    begin
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        if (len_reg != FRAME_LENGTH_WORD)
                            status = STATUS_BAD_LENGTH;
                        else if (sum_reg != word)
                            status = STATUS_BAD_CHECKSUM;
                        else
                            with_values = 1'b1;
                    end
                end
                default:
                begin
                    // Hunting, and any stray phase code
                    phase_next = (in_byte == START_FIRST) ? PH_SECOND : PH_HUNT;
                end
            endcase
        end
    end

    // Build the result; value words read zero on any error
    always_comb
    begin
        result.status = status;
        result.values = with_values ? value_reg : '0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
            len_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    // Store value words as they complete
    always_ff @(posedge clk)
    begin
        if (wr_en)
            value_reg[wr_idx] <= word;
    end

    `PSPF_ASSERT(a_emit_back_to_hunt, emit |=> phase_reg == PH_HUNT)
    `PSPF_ASSERT(a_collect_past_start, (phase_reg == PH_COLLECT) |-> (idx_reg >= IDX_FIRST_BODY))
    `PSPF_ASSERT(a_error_zero_values, (emit && status != STATUS_OK) |-> (result.values == '0))

endmodule

// ===== sv/pspf_out_queue.sv =====
// Two-entry result queue between the parser and the result channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pspf_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pspf_pkg::result_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pspf_pkg::result_t pop_data
);
    import pspf_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop        = pop_valid && pop_ready;
    assign pop_valid  = (count_reg != 2'd0);
    assign push_ready = (count_reg != 2'd2);
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Capture a new result beat
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `PSPF_ASSERT_ALWAYS(a_count_in_range, count_reg != 2'd3)
    `PSPF_ASSERT(a_no_push_when_full, (count_reg == 2'd2) |-> !push)
    `PSPF_ASSERT(a_pop_drains, (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)

endmodule

// ===== tb/sv/tb_particle_sensor_frame_parser_unit.sv =====
// Testbench for the particle sensor frame parser: directed table, random frames, scoreboard.
`timescale 1ns / 1ps
module tb_particle_sensor_frame_parser_unit;
    import pspf_pkg::*;

    typedef enum logic [1:0] {
        SEEK_FIRST  = 2'd0,
        SEEK_SECOND = 2'd1,
        GATHER      = 2'd2
    } parse_phase_e;

    typedef enum int {
        ROW_BYTE,
        ROW_FRAME
    } row_kind_e;

    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_LENGTH,
        SEQ_BAD_CHECKSUM,
        SEQ_BAD_START,
        SEQ_NOISE,
        SEQ_TRUNCATED
    } seq_kind_e;

    // One directed row: a single byte, or a whole frame filled with one byte value
    typedef struct {
        row_kind_e   kind;
        logic [7:0]  data;
        word_t       len;
        word_t       skew;
        bit          typed;
        status_t     status;
        word_t       value;
    } dir_row_t;

    localparam int FRAME_SIZE    = 32;
    localparam int RANDOM_BYTES  = 1320;
    localparam int DRAIN_LIMIT   = 20000;

    logic clk;
    logic rst_n;

    pspf_in_if  rx_if ();
    pspf_out_if frame_if ();

    particle_sensor_frame_parser_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if)
    );

    // Parser state as predicted by the testbench
    parse_phase_e psr_phase;
    logic [4:0]   psr_index;
    word_t        psr_sum;
    word_t        psr_length;
    word_t        psr_words [VALUE_COUNT];
    logic [7:0]   psr_high;

    result_t      expected_results [$];
    result_t      typed_result;
    bit           typed_armed;
    bit           calm;
    int           failures;
    logic [7:0]   stim_bytes [FRAME_SIZE];

    string value_names [VALUE_COUNT] = '{"pm1_0", "pm2_5", "pm10", "count_0_3", "count_0_5",
                                         "count_1_0", "count_2_5", "count_5_0", "count_10"};

    // Bytes, bad second start bytes, good frames at 00/FF, error frames, start-byte frames
    dir_row_t dir_rows [17] = '{
        '{ROW_BYTE,  8'h00,        16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  8'hFF,        16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  START_SECOND, 16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  START_FIRST,  16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  8'h00,        16'h0000, 16'h0000, 1'b1, STATUS_BAD_START,    16'h0000},
        '{ROW_BYTE,  START_FIRST,  16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  START_FIRST,  16'h0000, 16'h0000, 1'b1, STATUS_BAD_START,    16'h0000},
        '{ROW_BYTE,  START_SECOND, 16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  START_FIRST,  16'h0000, 16'h0000, 1'b0, STATUS_OK,           16'h0000},
        '{ROW_BYTE,  8'hFF,        16'h0000, 16'h0000, 1'b1, STATUS_BAD_START,    16'h0000},
        '{ROW_FRAME, 8'h00, FRAME_LENGTH_WORD, 16'h0000, 1'b1, STATUS_OK,         16'h0000},
        '{ROW_FRAME, 8'hFF, FRAME_LENGTH_WORD, 16'h0000, 1'b1, STATUS_OK,         16'hFFFF},
        '{ROW_FRAME, 8'h5A,        16'hFFFF, 16'h0000, 1'b1, STATUS_BAD_LENGTH,   16'h0000},
        '{ROW_FRAME, 8'hA5, FRAME_LENGTH_WORD, 16'h0001, 1'b1, STATUS_BAD_CHECKSUM, 16'h0000},
        '{ROW_FRAME, 8'h00,        16'h0000, 16'hFFFF, 1'b1, STATUS_BAD_LENGTH,   16'h0000},
        '{ROW_FRAME, START_FIRST,  FRAME_LENGTH_WORD, 16'h0000, 1'b0, STATUS_OK,  16'h0000},
        '{ROW_FRAME, START_SECOND, FRAME_LENGTH_WORD, 16'h0000, 1'b0, STATUS_OK,  16'h0000}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin : watchdog
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH @%0t: %s got %h expected %h", $time, what, got, want);
        failures++;
    endtask

    // Idle length: mostly none, some short, a few long; none during calm stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Byte biased toward the start markers and the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return START_FIRST;
            3: return START_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the predicted parser by one byte; return 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, output result_t res);
        word_t word;
        bit    done;
        int    k;
        done = 1'b0;
        res  = '0;
        word = {psr_high, b};
        case (psr_phase)
            SEEK_SECOND:
            begin
                if (b != START_SECOND)
                begin
                    psr_phase  = SEEK_FIRST;
                    res.status = STATUS_BAD_START;
                    done       = 1'b1;
                end
                else
                begin
                    psr_sum   = START_SUM;
                    psr_index = IDX_FIRST_BODY;
                    psr_phase = GATHER;
                end
            end
            GATHER:
            begin
                if (psr_index < IDX_SUM_END)
                    psr_sum = psr_sum + word_t'(b);
                if (!psr_index[0])
                    psr_high = b;
                else if (psr_index == IDX_LENGTH_LO)
                    psr_length = word;
                else if (psr_index >= IDX_VALUE_FIRST && psr_index <= IDX_VALUE_LAST)
                    psr_words[(psr_index - IDX_VALUE_FIRST) >> 1] = word;
                else if (psr_index == IDX_LAST)
                begin
                    // Length is checked ahead of the checksum; values only on success
                    psr_phase = SEEK_FIRST;
                    done      = 1'b1;
                    if (psr_length != FRAME_LENGTH_WORD)
                        res.status = STATUS_BAD_LENGTH;
                    else if (psr_sum != word)
                        res.status = STATUS_BAD_CHECKSUM;
                    else
                    begin
                        res.status = STATUS_OK;
                        for (k = 0; k < VALUE_COUNT; k++)
                            res.values[k] = psr_words[k];
                    end
                end
                psr_index = done ? 5'd0 : psr_index + 5'd1;
            end
            default:
                psr_phase = (b == START_FIRST) ? SEEK_SECOND : SEEK_FIRST;
        endcase
        return done;
    endfunction

    // Fill the frame buffer; skew is added to the correct checksum word
    function automatic void build_frame(input word_t len, input bit random_fill,
                                        input logic [7:0] fill, input word_t skew);
        word_t sum;
        int    i;
        stim_bytes[0] = START_FIRST;
        stim_bytes[1] = START_SECOND;
        stim_bytes[2] = len[15:8];
        stim_bytes[3] = len[7:0];
        for (i = 4; i < FRAME_SIZE - 2; i++)
            stim_bytes[i] = random_fill ? rand_byte() : fill;
        sum = '0;
        for (i = 0; i < FRAME_SIZE - 2; i++)
            sum = sum + word_t'(stim_bytes[i]);
        sum = sum + skew;
        stim_bytes[FRAME_SIZE - 2] = sum[15:8];
        stim_bytes[FRAME_SIZE - 1] = sum[7:0];
    endfunction

    // Drive one byte at the falling edge, hold until accepted, then predict
    task automatic send_byte(input logic [7:0] b);
        result_t     res;
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        if (parse_byte(b, res))
        begin
            if (typed_armed)
            begin
                expected_results.push_back(typed_result);
                typed_armed = 1'b0;
            end
            else
                expected_results.push_back(res);
        end
        @(negedge clk);
    endtask

    task automatic send_frame(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_byte(stim_bytes[i]);
    endtask

    // Result side: mix ready runs and stalls at random
    initial
    begin : result_sink
        int unsigned run;
        logic        level;
        frame_if.ready = 1'b0;
        forever
        begin
            if (calm || $urandom_range(0, 1) == 1)
            begin
                level = 1'b1;
                run   = $urandom_range(1, 12);
            end
            else
            begin
                level = 1'b0;
                run   = pick_gap();
                if (run == 0)
                    run = 1;
            end
            @(negedge clk);
            frame_if.ready <= level;
            repeat (run - 1) @(negedge clk);
        end
    end

    // Compare every delivered result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        word_t   seen [VALUE_COUNT];
        int      k;
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            seen[0] = frame_if.pm1_0;
            seen[1] = frame_if.pm2_5;
            seen[2] = frame_if.pm10;
            seen[3] = frame_if.count_0_3;
            seen[4] = frame_if.count_0_5;
            seen[5] = frame_if.count_1_0;
            seen[6] = frame_if.count_2_5;
            seen[7] = frame_if.count_5_0;
            seen[8] = frame_if.count_10;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, status", 16'(frame_if.status), 16'h0);
            else
            begin
                want = expected_results.pop_front();
                if (frame_if.status !== want.status)
                    report_mismatch("status", 16'(frame_if.status), 16'(want.status));
                for (k = 0; k < VALUE_COUNT; k++)
                    if (seen[k] !== want.values[k])
                        report_mismatch(value_names[k], seen[k], want.values[k]);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int          row;
        int          sent;
        int          k;
        int          waited;
        int          cut;
        int unsigned roll;
        seq_kind_e   kind;
        logic [7:0]  b;
        word_t       len;

        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        rst_n         = 1'b0;
        calm          = 1'b0;
        typed_armed   = 1'b0;
        failures      = 0;
        psr_phase     = SEEK_FIRST;
        psr_index     = '0;
        psr_sum       = '0;
        psr_length    = '0;
        psr_high      = '0;
        for (k = 0; k < VALUE_COUNT; k++)
            psr_words[k] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (row = 0; row < $size(dir_rows); row++)
        begin
            if (dir_rows[row].typed)
            begin
                typed_result        = '0;
                typed_result.status = dir_rows[row].status;
                for (k = 0; k < VALUE_COUNT; k++)
                    typed_result.values[k] = dir_rows[row].value;
                typed_armed = 1'b1;
            end
            if (dir_rows[row].kind == ROW_BYTE)
                send_byte(dir_rows[row].data);
            else
            begin
                build_frame(dir_rows[row].len, 1'b0, dir_rows[row].data, dir_rows[row].skew);
                send_frame(FRAME_SIZE);
            end
        end

        // Random frames, mostly well formed, with errors, noise and cut-off frames
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            calm = ($urandom_range(0, 7) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 55)
                kind = SEQ_GOOD;
            else if (roll < 65)
                kind = SEQ_BAD_LENGTH;
            else if (roll < 75)
                kind = SEQ_BAD_CHECKSUM;
            else if (roll < 87)
                kind = SEQ_BAD_START;
            else if (roll < 94)
                kind = SEQ_NOISE;
            else
                kind = SEQ_TRUNCATED;

            case (kind)
                SEQ_GOOD:
                begin
                    build_frame(FRAME_LENGTH_WORD, 1'b1, 8'h00, 16'h0000);
                    send_frame(FRAME_SIZE);
                    sent += FRAME_SIZE;
                end
                SEQ_BAD_LENGTH:
                begin
                    do
                    begin
                        if ($urandom_range(0, 2) == 0)
                            len = word_t'($urandom_range(0, 65535));
                        else
                            len = FRAME_LENGTH_WORD ^ (16'h0001 << $urandom_range(0, 15));
                    end
                    while (len == FRAME_LENGTH_WORD);
                    build_frame(len, 1'b1, 8'h00, 16'h0000);
                    send_frame(FRAME_SIZE);
                    sent += FRAME_SIZE;
                end
                SEQ_BAD_CHECKSUM:
                begin
                    if ($urandom_range(0, 1) == 0)
                        len = 16'h0001 << $urandom_range(0, 15);
                    else
                        len = word_t'($urandom_range(1, 65535));
                    build_frame(FRAME_LENGTH_WORD, 1'b1, 8'h00, len);
                    send_frame(FRAME_SIZE);
                    sent += FRAME_SIZE;
                end
                SEQ_BAD_START:
                begin
                    do
                        b = rand_byte();
                    while (b == START_SECOND);
                    send_byte(START_FIRST);
                    send_byte(b);
                    sent += 2;
                end
                SEQ_NOISE:
                begin
                    cut = $urandom_range(1, 6);
                    repeat (cut) send_byte(rand_byte());
                    sent += cut;
                end
                default:
                begin
                    build_frame(FRAME_LENGTH_WORD, 1'b1, 8'h00, 16'h0000);
                    cut = $urandom_range(2, FRAME_SIZE - 1);
                    send_frame(cut);
                    sent += cut;
                end
            endcase
        end
        calm = 1'b0;
        rx_if.valid <= 1'b0;

        // Drain outstanding results, then wait a little longer for strays
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 16'h0, 16'(expected_results.size()));

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
